// File: hdl/heq_pkg.sv
// Shared types and constants of the 8-bit histogram equalizer.
package heq_pkg;

	localparam int BINS   = 256;
	localparam int ADDR_W = 8;
	localparam int TBL_W  = 9;
	localparam int MAP_W  = 8;

	localparam logic [TBL_W-1:0] TBL_MAX = 9'd511;

	typedef enum logic [1:0] {
		CMD_ACCUM = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_MAP   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_NORMALIZE  = 2'd2;

	// memory read request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	// table write request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [TBL_W-1:0]  data;
	} tbl_wr_t;

endpackage

// File: hdl/histogram_equalizer_8bit.sv
// Top level of the 8-bit histogram equalizer.
//
// Input stream: s_axis_tdata carries the voxel, s_axis_tuser the command
// (accumulate, build, map, clear). Only map returns an item on the output
// stream: m_axis_tdata is the table value clamped to 255, m_axis_tuser
// flags the clamp.
// Accumulate, map and clear run back to back unless a stall holds the input.
// Accumulate is a read-modify-write of the bin memory, with the last
// write forwarded so equal voxels in a row count correctly.
// Map: the table read and the read stage register at the accepting edge.
// Build stops the input for a window sum sweep and a table sweep over the
// bin memory, with a bit-serial division for each normalized window entry
// when the window sum is not zero.
// Reset clears the control registers, the histogram valid bits and the
// table flag at once, so there is no clearing pass; clear zeroes the
// histogram the same way.
// When the receiver stalls, one result waits in the output register and
// one more in the read stage; input stops only when both are full.
// Configuration must be written over cfg_* while the block is idle; unchecked.
module histogram_equalizer_8bit #(
	parameter int COUNT_BITS = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] voxel
	input  logic [1:0] s_axis_tuser,  // [1:0] cmd
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] mapped_value
	output logic [0:0] m_axis_tuser,  // [0] clamped
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int AW = heq_pkg::ADDR_W;

	// configuration registers
	logic [7:0] range_low_q;
	logic [7:0] range_high_q;
	logic       normalize_q;

	logic              in_acc;
	heq_pkg::cmd_t     cmd;
	logic              build_busy;
	heq_pkg::mem_rd_t  build_rd;
	heq_pkg::mem_rd_t  bin_rd;
	heq_pkg::mem_rd_t  tbl_rd;
	heq_pkg::tbl_wr_t  tbl_wr;
	logic [COUNT_BITS-1:0] bin_data;
	logic [heq_pkg::TBL_W-1:0] tbl_data;

	// read stage
	logic          acc_s1_q;
	logic          map_s1_q;
	logic [AW-1:0] addr_s1;

	// forwarding of the last bin write
	logic                  fwd_vld_q;
	logic [AW-1:0]         fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic [COUNT_BITS-1:0] cnt_cur;
	logic [COUNT_BITS-1:0] cnt_nxt;

	// output register
	logic       out_vld_q;
	logic [7:0] out_val_q;
	logic       out_clamp_q;
	logic       move;
	logic       clr;

	assign cmd    = heq_pkg::cmd_t'(s_axis_tuser);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign clr    = in_acc && (cmd == heq_pkg::CMD_CLEAR);

	// config writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= 8'd0;
			range_high_q <= 8'd255;
			normalize_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				heq_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
				heq_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
				heq_pkg::REG_NORMALIZE:  normalize_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// bin memory port goes to the sequencer during a build
	always_comb begin
		if (build_busy) begin
			bin_rd = build_rd;
		end else begin
			bin_rd.en   = in_acc && (cmd == heq_pkg::CMD_ACCUM);
			bin_rd.addr = s_axis_tdata;
		end
	end

	assign tbl_rd.en   = in_acc && (cmd == heq_pkg::CMD_MAP);
	assign tbl_rd.addr = s_axis_tdata;

	heq_bin_store #(.COUNT_BITS(COUNT_BITS)) u_bins (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (bin_rd),
		.rd_data(bin_data),
		.wr_en  (acc_s1_q),
		.wr_addr(addr_s1),
		.wr_data(cnt_nxt),
		.clr    (clr)
	);

	heq_map_store u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (tbl_rd),
		.rd_data(tbl_data),
		.wr     (tbl_wr)
	);

	heq_build #(.COUNT_BITS(COUNT_BITS)) u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc && (cmd == heq_pkg::CMD_BUILD)),
		.range_low (range_low_q),
		.range_high(range_high_q),
		.normalize (normalize_q),
		.bin_rd    (build_rd),
		.bin_data  (bin_data),
		.tbl_wr    (tbl_wr),
		.busy      (build_busy)
	);

	// saturating increment; the previous edge's write is not yet in the read data
	assign cnt_cur = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : bin_data;
	assign cnt_nxt = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (clr) begin
			fwd_vld_q <= 1'b0;
		end else if (acc_s1_q) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1_q) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= cnt_nxt;
		end
		if (in_acc) begin
			addr_s1 <= s_axis_tdata;
		end
	end

	// map result leaves the read stage when the output register frees up
	assign move = map_s1_q && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !build_busy && !(map_s1_q && out_vld_q && !m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1_q  <= 1'b0;
			map_s1_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			acc_s1_q <= in_acc && (cmd == heq_pkg::CMD_ACCUM);
			if (in_acc) begin
				map_s1_q <= cmd == heq_pkg::CMD_MAP;
			end else if (move) begin
				map_s1_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_clamp_q <= tbl_data[heq_pkg::TBL_W-1];
			out_val_q   <= tbl_data[heq_pkg::TBL_W-1] ? 8'hFF : tbl_data[7:0];
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = out_val_q;
	assign m_axis_tuser[0] = out_clamp_q;

	// no input while the table is being built
	a_build_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		build_busy |-> !s_axis_tready)
		else $error("input accepted during build");

	// a build command starts the sequencer
	a_build_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == heq_pkg::CMD_BUILD) |=> build_busy)
		else $error("build did not start");

	// a map item always reaches the read stage
	a_map_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == heq_pkg::CMD_MAP) |=> map_s1_q)
		else $error("map item lost");

	// a clamped result carries full scale
	a_clamp_val: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 8'hFF))
		else $error("clamped result not 255");

endmodule

// File: hdl/heq_bin_store.sv
// Histogram bin memory with per-bin valid bits for reset and clear.
module heq_bin_store #(
	parameter int COUNT_BITS = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  heq_pkg::mem_rd_t             rd,
	output logic [COUNT_BITS-1:0]        rd_data,
	input  logic                         wr_en,
	input  logic [heq_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [COUNT_BITS-1:0]        wr_data,
	input  logic                         clr
);

	logic [COUNT_BITS-1:0]      mem [heq_pkg::BINS];
	logic [COUNT_BITS-1:0]      rdata_q;
	logic [heq_pkg::ADDR_W-1:0] raddr_q;
	logic [heq_pkg::BINS-1:0]   vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
			raddr_q <= rd.addr;
		end
	end

	// clear wins over a write landing on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = vld_q[raddr_q] ? rdata_q : '0;

endmodule

// File: hdl/heq_map_store.sv
// Lookup table memory; reads zero until the first build has written it.
module heq_map_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  heq_pkg::mem_rd_t            rd,
	output logic [heq_pkg::TBL_W-1:0]   rd_data,
	input  heq_pkg::tbl_wr_t            wr
);

	logic [heq_pkg::TBL_W-1:0] mem [heq_pkg::BINS];
	logic [heq_pkg::TBL_W-1:0] rdata_q;
	logic                      built_q;
	logic                      hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				built_q <= 1'b1;
			end
			if (rd.en) begin
				hit_q <= built_q;
			end
		end
	end

	assign rd_data = hit_q ? rdata_q : '0;

endmodule

// File: hdl/heq_div.sv
// Restoring divider, one quotient bit per cycle, for quotients below 2^QW.
module heq_div #(
	parameter int NW = 42,
	parameter int DW = 34
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NW-1:0]             num,
	input  logic [DW-1:0]             den,
	output logic                      done,
	output logic [heq_pkg::MAP_W-1:0] quo
);

	localparam int QW = heq_pkg::MAP_W;
	localparam int CW = $clog2(QW);

	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'({den, {(QW-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_q - dsh_q : rem_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW-1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hdl/heq_build.sv
// Table build sequencer: window sum sweep, then cumulative table sweep.
module heq_build #(
	parameter int COUNT_BITS = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [7:0]                  range_low,
	input  logic [7:0]                  range_high,
	input  logic                        normalize,
	output heq_pkg::mem_rd_t            bin_rd,
	input  logic [COUNT_BITS-1:0]       bin_data,
	output heq_pkg::tbl_wr_t            tbl_wr,
	output logic                        busy
);

	localparam int SW = COUNT_BITS + heq_pkg::ADDR_W;
	localparam int NW = SW + 9;
	localparam int DW = SW + 1;
	localparam int TW = heq_pkg::TBL_W;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SUM_RD  = 7'b0000010,
		ST_SUM_ADD = 7'b0000100,
		ST_MAP_RD  = 7'b0001000,
		ST_MAP_ACC = 7'b0010000,
		ST_NUM     = 7'b0100000,
		ST_DIV     = 7'b1000000
	} build_state_t;

	build_state_t               state_q, state_d;
	logic [heq_pkg::ADDR_W-1:0] idx_q;
	logic [SW-1:0]              sum_q;
	logic [SW-1:0]              run_q;
	logic [SW-1:0]              run_nx;
	logic [TW-1:0]              base_q;
	logic                       win, above;
	logic                       need_div;
	logic [TW-1:0]              val;
	logic [TW:0]                base_sum;
	logic                       wr_en;
	logic                       div_start;
	logic                       div_done;
	logic [heq_pkg::MAP_W-1:0]  div_quo;
	logic [NW-1:0]              num;

	assign above  = idx_q > range_high;
	assign win    = !above && (idx_q >= range_low);
	assign run_nx = run_q + (win ? SW'(bin_data) : '0);
	assign base_sum = {1'b0, base_q} + {2'b00, idx_q};
	assign need_div = win && normalize && (sum_q != '0);

	// 510*run + S
	assign num = {run_q, 9'd0} - NW'({run_q, 1'b0}) + NW'(sum_q);

	heq_div #(.NW(NW), .DW(DW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   ({sum_q, 1'b0}),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		val = '0;
		if (state_q == ST_DIV) begin
			val = TW'(div_quo);
		end else if (above) begin
			val = base_sum[TW] ? heq_pkg::TBL_MAX : base_sum[TW-1:0];
		end else if (win && !normalize) begin
			val = (run_nx > SW'(heq_pkg::TBL_MAX)) ? heq_pkg::TBL_MAX : run_nx[TW-1:0];
		end
	end

	assign wr_en = ((state_q == ST_MAP_ACC) && !need_div) || ((state_q == ST_DIV) && div_done);
	assign div_start = state_q == ST_NUM;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = ST_SUM_RD;
			ST_SUM_RD:  state_d = ST_SUM_ADD;
			ST_SUM_ADD: state_d = (&idx_q) ? ST_MAP_RD : ST_SUM_RD;
			ST_MAP_RD:  state_d = ST_MAP_ACC;
			ST_MAP_ACC: begin
				if (need_div) state_d = ST_NUM;
				else state_d = (&idx_q) ? ST_IDLE : ST_MAP_RD;
			end
			ST_NUM:     state_d = ST_DIV;
			ST_DIV:     if (div_done) state_d = (&idx_q) ? ST_IDLE : ST_MAP_RD;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_SUM_ADD || wr_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
			run_q <= '0;
			base_q <= '0;
		end else if (state_q == ST_SUM_ADD) begin
			if (win) begin
				sum_q <= sum_q + SW'(bin_data);
			end
		end else if (state_q == ST_MAP_ACC) begin
			run_q <= run_nx;
		end
		if (wr_en && idx_q == range_high) begin
			base_q <= val;
		end
	end

	assign bin_rd.en   = (state_q == ST_SUM_RD) || (state_q == ST_MAP_RD);
	assign bin_rd.addr = idx_q;
	assign tbl_wr.en   = wr_en;
	assign tbl_wr.addr = idx_q;
	assign tbl_wr.data = val;
	assign busy        = state_q != ST_IDLE;

endmodule

// File: test/tb_histogram_equalizer_8bit.sv
// Testbench of the 8-bit histogram equalizer: directed table, then random phases.
module tb_histogram_equalizer_8bit;

	localparam int CNT_BITS = 25;
	localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
	localparam int IDLE_PCT = 23;
	localparam int PHASE_ITEMS = 75;
	// longest build (a division at every table entry) plus margin
	localparam int BUILD_WAIT = 3700;
	localparam int CYCLE_LIMIT = 2000000;
	// index past the three registers, writes to it must change nothing
	localparam logic [1:0] REG_SPARE = 2'd3;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;                   // [7:0] voxel
	logic [1:0] s_axis_tuser = heq_pkg::CMD_ACCUM;   // [1:0] cmd
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;                        // [7:0] mapped_value
	logic [0:0] m_axis_tuser;                        // [0] clamped
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = heq_pkg::REG_RANGE_LOW;
	logic [7:0] cfg_data = '0;

	histogram_equalizer_8bit #(.COUNT_BITS(CNT_BITS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ---------------------------------------------------------------
	// Predictor state: histogram, lookup table and window registers
	// ---------------------------------------------------------------
	typedef struct {
		logic [7:0] mapped;
		logic       clamp;
	} map_exp_t;

	int unsigned               hist_bins [heq_pkg::BINS];
	logic [heq_pkg::TBL_W-1:0] lut [heq_pkg::BINS];
	int unsigned               win_lo = 0;
	int unsigned               win_hi = 255;
	logic                      norm_en = 1'b1;

	map_exp_t pending_maps [$];   // expected map items, oldest first

	bit calm = 1'b0;              // no idling on either side while set
	int n_fail = 0;
	int n_items = 0;
	int n_maps = 0;
	int n_builds = 0;
	int n_results = 0;
	int n_clamped = 0;
	int n_cfg = 0;
	int cycle_cnt = 0;

	initial begin
		foreach (hist_bins[i]) hist_bins[i] = 0;
		foreach (lut[i]) lut[i] = '0;
	end

	// Table build: cumulative sum over the window, optionally scaled to
	// 0..255 with round-half-up; entries above the window ride on the last
	// window entry plus the index. Everything saturates at the table width.
	function automatic void rebuild_lut();
		longint unsigned total;
		longint unsigned run;
		longint unsigned val;
		total = 0;
		run = 0;
		for (int i = 0; i < heq_pkg::BINS; i++)
			if (i >= win_lo && i <= win_hi)
				total += hist_bins[i];
		for (int i = 0; i < heq_pkg::BINS; i++) begin
			if (i > win_hi) begin
				val = longint'(lut[win_hi]) + i;
			end else if (i < win_lo) begin
				val = 0;
			end else begin
				run += hist_bins[i];
				if (!norm_en)
					val = run;
				else if (total == 0)
					val = 0;
				else
					val = (510 * run + total) / (2 * total);
			end
			lut[i] = (val > heq_pkg::TBL_MAX) ? heq_pkg::TBL_MAX : val[heq_pkg::TBL_W-1:0];
		end
	endfunction

	// ---------------------------------------------------------------
	// Item source: random gaps, then hold the item until accepted and
	// advance the predictor at the accepting edge
	// ---------------------------------------------------------------
	task automatic push_item(input heq_pkg::cmd_t c, input logic [7:0] v,
			input bit typed = 1'b0, input logic [7:0] exp_val = '0,
			input logic exp_clamp = 1'b0);
		map_exp_t e;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tuser  <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_items++;
		case (c)
			heq_pkg::CMD_ACCUM: begin
				// bins saturate instead of wrapping
				if (hist_bins[v] < CNT_MAX) hist_bins[v]++;
			end
			heq_pkg::CMD_BUILD: begin
				rebuild_lut();
				n_builds++;
			end
			heq_pkg::CMD_MAP: begin
				e.mapped = (lut[v] > 255) ? 8'd255 : lut[v][7:0];
				e.clamp  = (lut[v] > 255);
				if (typed) begin
					e.mapped = exp_val;
					e.clamp  = exp_clamp;
				end
				pending_maps.push_back(e);
				n_maps++;
			end
			heq_pkg::CMD_CLEAR: begin
				foreach (hist_bins[i]) hist_bins[i] = 0;
			end
		endcase
	endtask

	// valid stays up between writes; the caller drops it after the last one
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_cfg++;
		case (idx)
			heq_pkg::REG_RANGE_LOW:  win_lo = d;
			heq_pkg::REG_RANGE_HIGH: win_hi = d;
			heq_pkg::REG_NORMALIZE:  norm_en = d[0];
			default: ;
		endcase
	endtask

	task automatic set_window(input logic [7:0] lo, input logic [7:0] hi, input logic nm);
		write_reg(heq_pkg::REG_RANGE_LOW, lo);
		write_reg(heq_pkg::REG_RANGE_HIGH, hi);
		// upper bits are junk: the register keeps only bit 0
		write_reg(heq_pkg::REG_NORMALIZE, {7'($urandom), nm});
		write_reg(REG_SPARE, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Stop sending, wait for every map item to come back, then let a build
	// that produces nothing visible run out.
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_maps.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Result side: random stalls and in-order compare
	// ---------------------------------------------------------------
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin : result_check
		map_exp_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_maps.size() == 0) begin
				$error("unexpected item: mapped_value %0d clamped %0d",
					m_axis_tdata, m_axis_tuser[0]);
				n_fail++;
			end else begin
				e = pending_maps.pop_front();
				if (m_axis_tdata !== e.mapped) begin
					$error("mapped_value: expected %0d, got %0d", e.mapped, m_axis_tdata);
					n_fail++;
				end
				if (m_axis_tuser[0] !== e.clamp) begin
					$error("clamped: expected %0d, got %0d", e.clamp, m_axis_tuser[0]);
					n_fail++;
				end
				if (e.clamp) n_clamped++;
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Directed part, run under the reset settings (window 0..255,
	// normalized). Typed expectations: the table is all zero before the
	// first build, a zero total gives zeros, and the top window entry of a
	// normalized table is 255 once the total is not zero.
	// ---------------------------------------------------------------
	typedef struct {
		heq_pkg::cmd_t cmd;
		logic [7:0]    voxel;
		bit            typed;
		logic [7:0]    exp_val;
		logic          exp_clamp;
	} script_row_t;

	script_row_t script [25] = '{
		'{heq_pkg::CMD_MAP,   8'h00, 1'b1, 8'd0,   1'b0},   // stale table, low extreme
		'{heq_pkg::CMD_MAP,   8'hFF, 1'b1, 8'd0,   1'b0},   // stale table, high extreme
		'{heq_pkg::CMD_MAP,   8'hAA, 1'b1, 8'd0,   1'b0},
		'{heq_pkg::CMD_BUILD, 8'h00, 1'b0, 8'd0,   1'b0},   // empty histogram
		'{heq_pkg::CMD_MAP,   8'h55, 1'b1, 8'd0,   1'b0},   // zero total
		'{heq_pkg::CMD_ACCUM, 8'h00, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_ACCUM, 8'hFF, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_ACCUM, 8'hFF, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_ACCUM, 8'h80, 1'b0, 8'd0,   1'b0},   // same voxel back to back
		'{heq_pkg::CMD_ACCUM, 8'h80, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_ACCUM, 8'h80, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_ACCUM, 8'hAA, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_ACCUM, 8'h55, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_BUILD, 8'h3C, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'hFF, 1'b1, 8'd255, 1'b0},   // full window -> 255
		'{heq_pkg::CMD_MAP,   8'h00, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'h80, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'h55, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'hAA, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'h01, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_CLEAR, 8'hC3, 1'b0, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'h80, 1'b0, 8'd0,   1'b0},   // clear leaves the table alone
		'{heq_pkg::CMD_BUILD, 8'h00, 1'b0, 8'd0,   1'b0},   // zero total again
		'{heq_pkg::CMD_MAP,   8'h80, 1'b1, 8'd0,   1'b0},
		'{heq_pkg::CMD_MAP,   8'hFF, 1'b1, 8'd0,   1'b0}
	};

	// Random phases, one window setting each. big: a long accumulate run
	// so raw counts pass the table width. hold: sender waits mid-phase
	// until every map item is back. rnd: setting drawn at random.
	typedef struct {
		logic [7:0] lo;
		logic [7:0] hi;
		logic       norm;
		bit         calm;
		bit         big;
		bit         hold;
		bit         rnd;
	} phase_t;

	phase_t plan [8] = '{
		'{8'd0,   8'd255, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},   // reset values
		'{8'd0,   8'd255, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},   // raw, no idling
		'{8'd255, 8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},   // inverted window
		'{8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},   // single top bin
		'{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},   // single bottom bin
		'{8'd100, 8'd50,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0},   // inverted, raw
		'{8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1},
		'{8'd10,  8'd245, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}
	};

	initial begin : stimulus
		logic [7:0]    lo;
		logic [7:0]    hi;
		logic          nm;
		logic [7:0]    hot;
		int            start;
		int            r;
		bit            held;
		heq_pkg::cmd_t c;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			push_item(script[i].cmd, script[i].voxel, script[i].typed,
				script[i].exp_val, script[i].exp_clamp);
		drain(BUILD_WAIT);

		foreach (plan[p]) begin
			lo = plan[p].lo;
			hi = plan[p].hi;
			nm = plan[p].norm;
			if (plan[p].rnd) begin
				lo = 8'($urandom);
				hi = 8'($urandom);
				nm = 1'($urandom);
			end
			calm = plan[p].calm;
			set_window(lo, hi, nm);
			start = n_items;
			held = 1'b0;

			if (plan[p].big) begin
				// four bins share 600 voxels, so raw cumulative entries pass 511 and clamp
				repeat (600) push_item(heq_pkg::CMD_ACCUM, 8'($urandom_range(0, 3)));
				push_item(heq_pkg::CMD_BUILD, 8'($urandom));
				repeat (24) push_item(heq_pkg::CMD_MAP, 8'($urandom));
			end

			while (n_items - start < PHASE_ITEMS) begin
				if (plan[p].hold && !held && n_items - start >= PHASE_ITEMS / 2) begin
					drain(0);
					held = 1'b1;
				end
				if ($urandom_range(0, 99) < 75) begin
					// well-formed: (clear), accumulate, build, map
					if ($urandom_range(0, 2) != 0)
						push_item(heq_pkg::CMD_CLEAR, 8'($urandom));
					// half the voxels cluster at hot, which is near the window start half the time
					hot = $urandom_range(0, 1) ? lo ^ 8'($urandom_range(0, 7)) : 8'($urandom);
					repeat ($urandom_range(1, 40))
						push_item(heq_pkg::CMD_ACCUM, $urandom_range(0, 1) ?
							hot ^ 8'($urandom_range(0, 7)) : 8'($urandom));
					push_item(heq_pkg::CMD_BUILD, 8'($urandom));
					repeat ($urandom_range(4, 24))
						push_item(heq_pkg::CMD_MAP, ($urandom_range(0, 3) == 0) ?
							hot : 8'($urandom));
				end else begin
					// noise: any command, builds kept rare since each one is slow
					repeat ($urandom_range(1, 6)) begin
						r = $urandom_range(0, 15);
						c = (r == 0) ? heq_pkg::CMD_BUILD : (r < 7) ? heq_pkg::CMD_ACCUM :
							(r < 13) ? heq_pkg::CMD_MAP : heq_pkg::CMD_CLEAR;
						push_item(c, 8'($urandom));
					end
				end
			end
			drain(BUILD_WAIT);
			calm = 1'b0;
		end

		$display("%0d items sent (%0d maps, %0d builds), %0d register writes over %0d windows",
			n_items, n_maps, n_builds, n_cfg, $size(plan));
		$display("%0d map items compared, %0d of them clamped, %0d cycles",
			n_results, n_clamped, cycle_cnt);
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/heq_pkg.sv
hdl/heq_bin_store.sv
hdl/heq_map_store.sv
hdl/heq_div.sv
hdl/heq_build.sv
hdl/histogram_equalizer_8bit.sv
test/tb_histogram_equalizer_8bit.sv
